### rtl/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_62     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_63     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_CHAR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BAD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BREAKS = 3'd5;

  // Register values after reset.
  localparam logic [7:0] RST_CHAR_62  = 8'd43;
  localparam logic [7:0] RST_CHAR_63  = 8'd47;
  localparam logic [7:0] RST_PAD_CHAR = 8'd61;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  // Result queue: one group can push three results while earlier ones drain.
  localparam int unsigned QDEPTH = 6;
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_STRICT   = 2'd2,
    ST_LONE     = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       fin;
    status_e    status;
  } res_t;

  typedef struct packed {
    logic           fail;
    logic [1:0]     n;
    res_t [2:0]     res;
  } grp_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] val;
  } lut_t;

  localparam res_t RES_IDLE = '{data: 8'd0, valid: 1'b0, fin: 1'b0, status: ST_OK};

  // Standard alphabet; the two configurable characters are checked last.
  function automatic lut_t b64d_lookup(input logic [7:0] b, input logic [7:0] c62,
                                       input logic [7:0] c63);
    lut_t r;
    r.hit = 1'b1;
    r.val = 6'd0;
    if (b >= "A" && b <= "Z") begin
      r.val = 6'(b - 8'd65);
    end else if (b >= "a" && b <= "z") begin
      r.val = 6'(b - 8'd71);
    end else if (b >= "0" && b <= "9") begin
      r.val = 6'(b + 8'd4);
    end else if (b == c62) begin
      r.val = 6'd62;
    end else if (b == c63) begin
      r.val = 6'd63;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  // Turns a four-sextet word into its decoded bytes, or one strict error.
  function automatic grp_t b64d_group(input logic [23:0] word, input logic skip2,
                                      input logic skip1, input logic strict,
                                      input logic at_end);
    grp_t g;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    b0 = word[23:16];
    b1 = word[15:8];
    b2 = word[7:0];
    g.fail = strict && ((skip2 && (b1 != 8'd0 || b2 != 8'd0)) ||
                        (skip1 && b2 != 8'd0));
    g.res[0] = '{data: b0, valid: 1'b1, fin: 1'b0, status: ST_OK};
    g.res[1] = '{data: b1, valid: 1'b1, fin: 1'b0, status: ST_OK};
    g.res[2] = '{data: b2, valid: 1'b1, fin: at_end, status: ST_OK};
    if (g.fail) begin
      g.n = 2'd1;
      g.res[0] = '{data: 8'd0, valid: 1'b0, fin: 1'b1, status: ST_STRICT};
    end else if (skip2) begin
      g.n = 2'd1;
      g.res[0].fin = at_end;
    end else if (skip1) begin
      g.n = 2'd2;
      g.res[1].fin = at_end;
    end else begin
      g.n = 2'd3;
    end
    return g;
  endfunction

endpackage

### rtl/base64_stream_decoder.sv
`timescale 1ns / 1ps

// Base64 stream decoder. One text character enters per item on the input
// channel (in_valid_i / in_ready_o); an item with end_marker_i set closes
// the message and flushes a partial group. Decoded bytes and status items
// leave one per item on the output channel (out_valid_o / out_ready_i).
// Configuration registers are written over the cfg channel, which is always
// ready; write them only while no item is in flight.
// Results are registered and queue behind any still waiting. Throughput:
// one input item per cycle; in_ready_o drops while more than three results
// wait, which happens only when the receiver stalls. A completed group of
// four characters yields up to three results at once; they sit in a
// six-entry result queue and drain one per cycle while taken, so a steady
// stream of one character per cycle never stalls on a receiver that always
// takes. Reset empties the queue, clears the group and error state and
// restores the default alphabet, pad and mode registers.
module base64_stream_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    text_byte_i,
  input  logic                          end_marker_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    data_byte_o,
  output logic                          byte_valid_o,
  output logic                          final_result_o,
  output logic [1:0]                    status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [b64d_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);
  import b64d_pkg::*;

  logic [7:0] c62_q, c63_q, pad_q;
  logic       skip_bad_q, strict_q, crlf_q;

  logic [17:0] buf_q, buf_d;
  logic [1:0]  pos_q, pos_d;
  logic [2:0]  skip_q, skip_d;
  logic        halt_q, halt_d;

  res_t           q_q [QDEPTH];
  res_t           q_d [QDEPTH];
  logic [QCW-1:0] cnt_q, cnt_d;

  logic           acc, pop;
  logic [QCW-1:0] base;
  logic [QCW-1:0] off;
  logic [1:0]     n_res;
  res_t [2:0]     res;

  lut_t        lut;
  logic        is_pad, is_brk;
  logic [5:0]  sext;
  logic [2:0]  skip_n;
  logic [3:0]  skip_end;
  logic [23:0] end_word;
  grp_t        grp_full, grp_end;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = cnt_q <= QCW'(QDEPTH - 3);
  assign acc         = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c62_q      <= RST_CHAR_62;
      c63_q      <= RST_CHAR_63;
      pad_q      <= RST_PAD_CHAR;
      skip_bad_q <= 1'b1;
      strict_q   <= 1'b0;
      crlf_q     <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CHAR_62:     c62_q      <= cfg_data_i;
        CFG_CHAR_63:     c63_q      <= cfg_data_i;
        CFG_PAD_CHAR:    pad_q      <= cfg_data_i;
        CFG_SKIP_BAD:    skip_bad_q <= cfg_data_i[0];
        CFG_STRICT:      strict_q   <= cfg_data_i[0];
        CFG_LINE_BREAKS: crlf_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Character classification and group assembly.
  always_comb begin
    lut      = b64d_lookup(text_byte_i, c62_q, c63_q);
    is_pad   = (pad_q != 8'd0) && (text_byte_i == pad_q);
    is_brk   = crlf_q && (text_byte_i == CHAR_CR || text_byte_i == CHAR_LF);
    sext     = is_pad ? 6'd0 : lut.val;
    skip_n   = (is_pad && skip_q != 3'd7) ? skip_q + 3'd1 : skip_q;
    // A flush fills the missing sextets with zeros and counts them as skipped.
    skip_end = {1'b0, skip_q} + 4'd4 - {2'b00, pos_q};
    end_word = (pos_q == 2'd2) ? {buf_q[11:0], 12'd0} : {buf_q, 6'd0};
    grp_full = b64d_group({buf_q, sext}, skip_n >= 3'd2, skip_n == 3'd1,
                          strict_q, 1'b0);
    grp_end  = b64d_group(end_word, skip_end >= 4'd2, skip_end == 4'd1,
                          strict_q, 1'b1);

    buf_d  = buf_q;
    pos_d  = pos_q;
    skip_d = skip_q;
    halt_d = halt_q;
    n_res  = 2'd0;
    res    = {RES_IDLE, RES_IDLE, RES_IDLE};

    if (acc) begin
      if (end_marker_i) begin
        buf_d  = '0;
        pos_d  = '0;
        skip_d = '0;
        halt_d = 1'b0;
        if (!halt_q && pos_q == 2'd1) begin
          n_res  = 2'd1;
          res[0] = '{data: 8'd0, valid: 1'b0, fin: 1'b1, status: ST_LONE};
        end else if (!halt_q && pos_q >= 2'd2) begin
          n_res = grp_end.n;
          res   = grp_end.res;
        end
      end else if (!halt_q) begin
        if (is_pad || lut.hit) begin
          skip_d = skip_n;
          if (pos_q != 2'd3) begin
            buf_d = {buf_q[11:0], sext};
            pos_d = pos_q + 2'd1;
          end else begin
            buf_d  = '0;
            pos_d  = '0;
            skip_d = '0;
            n_res  = grp_full.n;
            res    = grp_full.res;
            halt_d = grp_full.fail;
          end
        end else if (!is_brk && !skip_bad_q) begin
          buf_d  = '0;
          pos_d  = '0;
          skip_d = '0;
          halt_d = 1'b1;
          n_res  = 2'd1;
          res[0] = '{data: 8'd0, valid: 1'b0, fin: 1'b1, status: ST_BAD_CHAR};
        end
      end
    end
  end

  // Result queue: entry zero is the output register; a pop shifts the rest
  // down and new results land right behind the survivors.
  always_comb begin
    base  = cnt_q - QCW'(pop);
    cnt_d = base + QCW'(n_res);
    off   = '0;
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        q_d[i] = q_q[i + 1];
      end else begin
        q_d[i] = q_q[i];
      end
      off = QCW'(i) - base;
      if (QCW'(i) >= base && off < QCW'(n_res)) begin
        q_d[i] = res[off[1:0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      pos_q  <= '0;
      skip_q <= '0;
      halt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      buf_q  <= buf_d;
      pos_q  <= pos_d;
      skip_q <= skip_d;
      halt_q <= halt_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign out_valid_o    = cnt_q != '0;
  assign data_byte_o    = q_q[0].data;
  assign byte_valid_o   = q_q[0].valid;
  assign final_result_o = q_q[0].fin;
  assign status_o       = q_q[0].status;

endmodule

### rtl/b64d_checker.sv
`timescale 1ns / 1ps

module b64d_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [7:0]                    data_byte_o,
  input logic                          byte_valid_o,
  input logic                          final_result_o,
  input logic [1:0]                    status_o
);
  import b64d_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(data_byte_o) && $stable(byte_valid_o)
      && $stable(final_result_o) && $stable(status_o))
    else $error("stalled result changed");

  // A result without a byte is always a closing status item.
  a_status_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> final_result_o && data_byte_o == 8'd0
      && status_o != ST_OK)
    else $error("status item malformed");

  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> status_o == ST_OK)
    else $error("decoded byte carries an error status");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);

### verif/base64_stream_decoder_tb.sv
`timescale 1ns / 1ps

module base64_stream_decoder_tb;
  import b64d_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 430;
  localparam int unsigned PHASE_ITEMS  = 40;

  // Tracks decoder state and configuration, and holds the decoded bytes and
  // status items still owed by the block.
  class decoded_byte_board;
    res_t        owed_results[$];
    int          fails;
    logic [7:0]  ch62;
    logic [7:0]  ch63;
    logic [7:0]  pad;
    bit          drop_bad;
    bit          strict;
    bit          crlf_ok;
    logic [17:0] sextets;
    logic [1:0]  slot;
    logic [2:0]  skips;
    bit          halted;

    function new();
      ch62     = RST_CHAR_62;
      ch63     = RST_CHAR_63;
      pad      = RST_PAD_CHAR;
      drop_bad = 1'b1;
      strict   = 1'b0;
      crlf_ok  = 1'b1;
      fails    = 0;
      halted   = 1'b0;
      clear_group();
    endfunction

    function void clear_group();
      sextets = '0;
      slot    = '0;
      skips   = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_CHAR_62:     ch62 = val;
        CFG_CHAR_63:     ch63 = val;
        CFG_PAD_CHAR:    pad = val;
        CFG_SKIP_BAD:    drop_bad = val[0];
        CFG_STRICT:      strict = val[0];
        CFG_LINE_BREAKS: crlf_ok = val[0];
        default: ;
      endcase
    endfunction

    function int sextet_of(logic [7:0] b);
      if (b >= "A" && b <= "Z") return int'(b) - 65;
      if (b >= "a" && b <= "z") return int'(b) - 97 + 26;
      if (b >= "0" && b <= "9") return int'(b) - 48 + 52;
      if (b == ch62) return 62;
      if (b == ch63) return 63;
      return -1;
    endfunction

    function void add_expected(logic [7:0] d, logic v, logic f, status_e s);
      owed_results.push_back('{data: d, valid: v, fin: f, status: s});
    endfunction

    // Returns 0 when the strict check rejects the group.
    function bit emit_group(logic [23:0] word, int skip, bit at_end);
      int n;
      if (strict && ((skip >= 2 && word[15:0] != 16'd0) ||
                     (skip == 1 && word[7:0] != 8'd0))) begin
        add_expected(8'd0, 1'b0, 1'b1, ST_STRICT);
        return 1'b0;
      end
      n = (skip >= 2) ? 1 : (skip == 1) ? 2 : 3;
      for (int k = 0; k < n; k++)
        add_expected(word[23 - 8*k -: 8], 1'b1, at_end && k == n - 1, ST_OK);
      return 1'b1;
    endfunction

    function void take_char(logic [7:0] ch, bit eom);
      int          pos;
      int          skip;
      int          v;
      logic [17:0] held;
      logic [5:0]  val;
      logic [23:0] word;
      bit          was_halted;
      if (eom) begin
        pos        = slot;
        skip       = skips;
        held       = sextets;
        was_halted = halted;
        clear_group();
        halted = 1'b0;
        if (was_halted || pos == 0) return;
        if (pos == 1) begin
          add_expected(8'd0, 1'b0, 1'b1, ST_LONE);
          return;
        end
        // Missing sextets are zero and count as skipped.
        word = (pos == 2) ? {held[11:0], 12'd0} : {held, 6'd0};
        void'(emit_group(word, skip + 4 - pos, 1'b1));
        return;
      end
      if (halted) return;
      if (pad != 8'd0 && ch == pad) begin
        val = '0;
        if (skips != 3'd7) skips++;
      end else begin
        v = sextet_of(ch);
        if (v >= 0) begin
          val = 6'(v);
        end else if (crlf_ok && (ch == CHAR_CR || ch == CHAR_LF)) begin
          return;
        end else if (drop_bad) begin
          return;
        end else begin
          add_expected(8'd0, 1'b0, 1'b1, ST_BAD_CHAR);
          clear_group();
          halted = 1'b1;
          return;
        end
      end
      if (slot != 2'd3) begin
        sextets = {sextets[11:0], val};
        slot++;
        return;
      end
      word = {sextets, val};
      skip = skips;
      clear_group();
      if (!emit_group(word, skip, 1'b0)) halted = 1'b1;
    endfunction

    function void match_result(res_t got);
      res_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual data=%h valid=%b %s%b %s%0d",
                 $time, got.data, got.valid, "final=", got.fin, "status=", got.status);
        fails++;
        return;
      end
      want = owed_results.pop_front();
      if (got.data !== want.data) begin
        $display("%0t: data_byte: expected %h, actual %h", $time, want.data, got.data);
        fails++;
      end
      if (got.valid !== want.valid) begin
        $display("%0t: byte_valid: expected %b, actual %b", $time, want.valid, got.valid);
        fails++;
      end
      if (got.fin !== want.fin) begin
        $display("%0t: final_result: expected %b, actual %b", $time, want.fin, got.fin);
        fails++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status: expected %0d, actual %0d", $time, want.status, got.status);
        fails++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           text_byte_i = 8'd0;
  logic                 end_marker_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [7:0]           data_byte_o;
  logic                 byte_valid_o;
  logic                 final_result_o;
  logic [1:0]           status_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0]           cfg_data_i = 8'd0;

  decoded_byte_board board = new();
  bit                calm = 1'b0;
  int unsigned       items_sent = 0;
  int unsigned       stall_left = 0;
  int unsigned       cycle_count = 0;

  base64_stream_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .end_marker_i  (end_marker_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .byte_valid_o  (byte_valid_o),
    .final_result_o(final_result_o),
    .status_o      (status_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("base64_stream_decoder_tb: FAIL");
      $finish;
    end
  end

  // Receiver: drops out_ready_i at random, in bursts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.match_result('{data: data_byte_o, valid: byte_valid_o, fin: final_result_o,
                           status: status_e'(status_o)});
  end

  task automatic push_char(input logic [7:0] ch, input logic eom);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    text_byte_i  <= ch;
    end_marker_i <= eom;
    do @(posedge clk_i); while (!in_ready_o);
    board.take_char(ch, eom);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
  endtask

  task automatic end_message();
    push_char(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Holds the input side until every owed result has been taken.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.owed_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, val);
  endtask

  task automatic configure(input logic [7:0] c62, input logic [7:0] c63,
                           input logic [7:0] pc, input bit sb, input bit st,
                           input bit lb);
    settle();
    write_reg(CFG_CHAR_62, c62);
    write_reg(CFG_CHAR_63, c63);
    write_reg(CFG_PAD_CHAR, pc);
    write_reg(CFG_SKIP_BAD, {7'd0, sb});
    write_reg(CFG_STRICT, {7'd0, st});
    write_reg(CFG_LINE_BREAKS, {7'd0, lb});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] char_for(int v);
    if (v < 26) return 8'(65 + v);
    if (v < 52) return 8'(97 + v - 26);
    if (v < 62) return 8'(48 + v - 52);
    return (v == 62) ? board.ch62 : board.ch63;
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 3))
      0: return CHAR_CR;
      1: return CHAR_LF;
      2: return board.pad;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A message of whole groups, some with pad tails, then a partial group and
  // the end marker. Most groups keep the bits dropped by padding at zero so
  // that strict mode lets them through.
  task automatic send_message();
    int groups;
    int len;
    int tail;
    int v;
    int r;
    bit tidy;
    groups = $urandom_range(0, 3);
    for (int g = 0; g <= groups; g++) begin
      if (g == groups) begin
        len  = $urandom_range(0, 3);
        tail = 4 - len;
      end else begin
        r    = $urandom_range(0, 9);
        tail = (board.pad == 8'd0 || r < 6) ? 0 : (r < 8) ? 1 : 2;
        len  = 4 - tail;
      end
      tidy = ($urandom_range(0, 9) < 7);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 19) == 0) push_char(noise_char(), 1'b0);
        v = $urandom_range(0, 63);
        if (tidy && tail >= 2 && k == 1) v = v & 'h30;
        if (tidy && tail == 1 && k == 2) v = v & 'h3c;
        push_char(char_for(v), 1'b0);
      end
      if (g != groups)
        for (int k = 0; k < tail; k++) push_char(board.pad, 1'b0);
    end
    end_message();
  endtask

  initial begin
    int unsigned random_start;
    int unsigned phase_end;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default alphabet: one pad, the two configurable characters, dropped
    // bytes, a lone sextet, a two-sextet flush and an empty message.
    send_text("TWE=");
    send_text("/+9z");
    push_char(CHAR_CR, 1'b0);
    push_char(CHAR_LF, 1'b0);
    push_char("*", 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'hff, 1'b0);
    send_text("A");
    end_message();
    send_text("AB");
    end_message();
    end_message();

    // Errors: a strict failure halts until the end marker, then a bad byte.
    configure(RST_CHAR_62, RST_CHAR_63, RST_PAD_CHAR, 1'b0, 1'b1, 1'b1);
    send_text("QR==");
    send_text("A");
    end_message();
    send_text("*");
    end_message();

    random_start = items_sent;
    for (int p = 0; items_sent - random_start < RANDOM_ITEMS; p++) begin
      case (p)
        0: configure(RST_CHAR_62, RST_CHAR_63, RST_PAD_CHAR, 1'b1, 1'b0, 1'b1);
        1: configure(8'h00, 8'hff, 8'h00, 1'b0, 1'b1, 1'b0);
        2: configure(8'hff, 8'h00, 8'hff, 1'b1, 1'b1, 1'b1);
        3: configure(CHAR_CR, CHAR_LF, "A", 1'b0, 1'b0, 1'b1);
        4: configure("-", "-", "=", 1'b1, 1'b1, 1'b0);
        default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent - random_start < RANDOM_ITEMS) begin
        calm = (items_sent - random_start) > 370;
        send_message();
        if (!calm && $urandom_range(0, 11) == 0) settle();
      end
    end

    in_valid_i <= 1'b0;
    while (board.owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.fails == 0) begin
      $display("base64_stream_decoder_tb: PASS");
    end else begin
      $display("base64_stream_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule
